### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
// Each macro expects clk, and the first two also rst_n, to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define VEL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define VEL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked during reset.
`define VEL_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hw/rtl/vel_pkg.sv
// Shared types, character codes and escape helpers for the visible escape folder.
// No dependencies; the files that use it refer to it by scoped names.
`timescale 1ns / 1ps

package vel_pkg;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] FOLD_RST = 8'd71;
  localparam logic [7:0] FOLD_MIN = 8'd4;
  localparam int         QDEPTH   = 4;
  localparam int         QAW      = $clog2(QDEPTH);

  // How an input byte is rendered.
  typedef enum logic [1:0] {
    K_EOL,   // end of line: lone newline, column restarts
    K_LIT,   // one character as is (printable or newline)
    K_CTL,   // backslash and two octal digits
    K_OCT    // backslash and three octal digits
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] code;
  } desc_t;

  typedef enum logic [1:0] {
    F_NONE,
    F_BSL,
    F_NL
  } fold_t;

  function automatic logic [1:0] last_idx(input kind_t kind);
    logic [1:0] r;
    case (kind)
      K_CTL:   r = 2'd2;
      K_OCT:   r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] octal(input logic [2:0] d);
    return CH_ZERO | {5'd0, d};
  endfunction

  // Character at position idx of the rendering of an escaped or literal byte.
  function automatic logic [7:0] esc_char(input desc_t d, input logic [1:0] idx);
    logic [7:0] r;
    r = CH_BSL;
    case (idx)
      2'd0: r = (d.kind == K_LIT) ? d.code : CH_BSL;
      2'd1: r = (d.kind == K_CTL) ? octal(d.code[5:3]) : octal({1'b0, d.code[7:6]});
      2'd2: r = (d.kind == K_CTL) ? octal(d.code[2:0]) : octal(d.code[5:3]);
      2'd3: r = octal(d.code[2:0]);
      default: r = CH_BSL;
    endcase
    return r;
  endfunction

endpackage

### hw/rtl/vel_in_if.sv
// Input channel: one line byte per word, valid/ready handshake.
// Depends on nothing.
`timescale 1ns / 1ps

interface vel_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] line_byte;

  modport source (output valid, output line_byte, input ready);
  modport sink   (input valid, input line_byte, output ready);
endinterface

### hw/rtl/vel_out_if.sv
// Result channel: one visible character per word plus an end-of-run flag.
// Depends on nothing.
`timescale 1ns / 1ps

interface vel_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       last_of_run;

  modport source (output valid, output out_char, output last_of_run, input ready);
  modport sink   (input valid, input out_char, input last_of_run, output ready);
endinterface

### hw/rtl/vel_cfg_if.sv
// Configuration channel: writes the fold width register.
// Depends on nothing.
`timescale 1ns / 1ps

interface vel_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] fold_width;

  modport source (output valid, output fold_width, input ready);
  modport sink   (input valid, input fold_width, output ready);
endinterface

### hw/rtl/vel_front.sv
// Front end: accepts line bytes and classifies each into a render descriptor.
// Depends on vel_pkg.
`timescale 1ns / 1ps

module vel_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  output logic           push,
  output vel_pkg::desc_t push_desc,
  input  logic           q_full
);

  logic           fr_valid_r, fr_valid_nxt;
  vel_pkg::desc_t fr_desc_r, fr_desc_nxt;
  vel_pkg::kind_t kind;
  logic           take;

  always_comb begin
    if (in_byte == 8'd0) begin
      kind = vel_pkg::K_EOL;
    end else if (in_byte == vel_pkg::CH_NL) begin
      kind = vel_pkg::K_LIT;
    end else if (in_byte inside {[8'd1:8'd31]}) begin
      kind = vel_pkg::K_CTL;
    end else if (in_byte inside {[8'd32:8'd126]}) begin
      kind = vel_pkg::K_LIT;
    end else begin
      kind = vel_pkg::K_OCT;
    end
  end

  assign push     = fr_valid_r && !q_full;
  assign in_ready = !fr_valid_r || push;
  assign take     = in_valid && in_ready;

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    fr_desc_nxt  = fr_desc_r;
    if (take) begin
      fr_valid_nxt = 1'b1;
      fr_desc_nxt  = '{kind: kind, code: in_byte};
    end else if (push) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
    fr_desc_r <= fr_desc_nxt;
  end

  assign push_desc = fr_desc_r;

endmodule

### hw/rtl/vel_queue.sv
// Short descriptor queue between the front end and the expander.
// Depends on vel_pkg.
`timescale 1ns / 1ps

module vel_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  vel_pkg::desc_t push_desc,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output vel_pkg::desc_t head_desc
);

  vel_pkg::desc_t             mem_r [vel_pkg::QDEPTH];
  logic [vel_pkg::QAW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [vel_pkg::QAW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [vel_pkg::QAW:0]      cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign full       = (cnt_r == (vel_pkg::QAW+1)'(vel_pkg::QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_desc  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### hw/rtl/vel_back.sv
// Back end: expands descriptors into characters, tracks the column and folds.
// Depends on vel_pkg.
`timescale 1ns / 1ps

module vel_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [7:0]     fold_width,
  input  logic           head_valid,
  input  vel_pkg::desc_t head_desc,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [7:0]     out_char,
  output logic           out_last
);

  logic [1:0]     idx_r, idx_nxt;
  vel_pkg::fold_t fold_r, fold_nxt;
  logic           fold_last_r, fold_last_nxt;
  logic [7:0]     col_r, col_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [7:0]     out_char_r, out_char_nxt;
  logic           out_last_r, out_last_nxt;

  logic           fire;
  logic           is_end;
  logic [7:0]     width;
  logic [8:0]     col_inc;
  logic [7:0]     ch;

  assign width   = (fold_width < vel_pkg::FOLD_MIN) ? vel_pkg::FOLD_MIN : fold_width;
  assign col_inc = {1'b0, col_r} + 9'd1;
  assign is_end  = (idx_r == vel_pkg::last_idx(head_desc.kind));
  assign ch      = vel_pkg::esc_char(head_desc, idx_r);
  // The output register takes a new character whenever a descriptor is waiting and it is empty or being drained.
  assign fire    = head_valid && (!out_valid_r || out_ready);

  always_comb begin
    idx_nxt       = idx_r;
    fold_nxt      = fold_r;
    fold_last_nxt = fold_last_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    if (fire) begin
      out_valid_nxt = 1'b1;
      case (fold_r)
        vel_pkg::F_BSL: begin
          out_char_nxt = vel_pkg::CH_BSL;
          out_last_nxt = 1'b0;
          fold_nxt     = vel_pkg::F_NL;
        end
        vel_pkg::F_NL: begin
          out_char_nxt = vel_pkg::CH_NL;
          out_last_nxt = fold_last_r;
          col_nxt      = '0;
          fold_nxt     = vel_pkg::F_NONE;
          if (fold_last_r) begin
            pop     = 1'b1;
            idx_nxt = '0;
          end else begin
            idx_nxt = idx_r + 2'd1;
          end
        end
        default: begin
          if (head_desc.kind == vel_pkg::K_EOL) begin
            out_char_nxt = vel_pkg::CH_NL;
            out_last_nxt = 1'b1;
            col_nxt      = '0;
            pop          = 1'b1;
            idx_nxt      = '0;
          end else if (col_inc >= {1'b0, width}) begin
            // Line is full: the fold follows this character before the next one.
            out_char_nxt  = ch;
            out_last_nxt  = 1'b0;
            fold_nxt      = vel_pkg::F_BSL;
            fold_last_nxt = is_end;
          end else begin
            out_char_nxt = ch;
            out_last_nxt = is_end;
            col_nxt      = col_inc[7:0];
            if (is_end) begin
              pop     = 1'b1;
              idx_nxt = '0;
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      fold_r      <= vel_pkg::F_NONE;
      col_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      fold_r      <= fold_nxt;
      col_r       <= col_nxt;
      out_valid_r <= out_valid_nxt;
    end
    fold_last_r <= fold_last_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

### hw/rtl/visible_escape_line_folder.sv
// Visible escape line folder. Line bytes enter on in_ch (valid/ready), one
// word per byte; a zero byte ends the line. Visible characters leave on
// out_ch, one word per character, with last_of_run high on the final
// character produced for a byte. cfg_ch writes the fold width (reset 71,
// values below 4 act as 4); cfg_ch.ready is always high, and writes are
// meant for when the block is idle.
// The first character of a byte passes the classify register, then the queue,
// then the output register before it is offered.
// Throughput: one character per cycle while out_ch is ready, set by the
// single output register. A byte yields one character (printable,
// newline, end of line), three (control byte) or four (byte 127 and above),
// plus a backslash and newline for each fold. A four-entry descriptor queue
// lets input keep flowing while a long escape is still being expanded.
// Reset (rst_n low, synchronous) empties the queue and output register,
// clears the column and sets the fold width to 71. When the receiver
// stalls, the current character holds on out_ch and input backs up
// through the queue until in_ch.ready drops.
// Depends on vel_pkg, the channel interfaces, vel_front, vel_queue, vel_back.
`timescale 1ns / 1ps

module visible_escape_line_folder (
  input  logic       clk,
  input  logic       rst_n,
  vel_in_if.sink     in_ch,
  vel_out_if.source  out_ch,
  vel_cfg_if.sink    cfg_ch
);

  logic [7:0]     fold_width_r, fold_width_nxt;
  logic           push, q_full, pop, head_valid;
  vel_pkg::desc_t push_desc, head_desc;

  assign cfg_ch.ready = 1'b1;
  assign fold_width_nxt = (cfg_ch.valid && cfg_ch.ready) ? cfg_ch.fold_width : fold_width_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_width_r <= vel_pkg::FOLD_RST;
    end else begin
      fold_width_r <= fold_width_nxt;
    end
  end

  vel_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_byte   (in_ch.line_byte),
    .push      (push),
    .push_desc (push_desc),
    .q_full    (q_full)
  );

  vel_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_desc  (head_desc)
  );

  vel_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fold_width (fold_width_r),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_char   (out_ch.out_char),
    .out_last   (out_ch.last_of_run)
  );

endmodule

### hw/rtl/vel_checker.sv
// Port-level checks for the visible escape line folder, bound to the top level.
// Depends on assert_macros.svh and the top level's channel ports.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vel_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last,
  input logic       cfg_ready
);

  // A stalled output word must hold.
  `VEL_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(out_last))
  // Only newline and printable ASCII ever leave the block.
  `VEL_ASSERT_IMP(a_out_visible, out_valid, (out_char == 8'd10) || ((out_char >= 8'd32) && (out_char <= 8'd126)))
  // Nothing is offered in the cycle after reset.
  `VEL_ASSERT_RST(a_reset_quiet, !rst_n, !out_valid)
  // The configuration port never pushes back.
  `VEL_ASSERT_IMP(a_cfg_ready, 1'b1, cfg_ready)

endmodule

bind visible_escape_line_folder vel_checker u_vel_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .out_last  (out_ch.last_of_run),
  .cfg_ready (cfg_ch.ready)
);

### test/visible_escape_line_folder_test.sv
// Self-checking testbench for visible_escape_line_folder: drives line bytes, predicts
// every visible character with its end-of-run flag, and checks the result channel.
// Depends on vel_pkg, the three channel interfaces and the top-level RTL module.
`timescale 1ns / 1ps

module visible_escape_line_folder_test;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } vis_word_t;

  logic clk;
  logic rst_n;

  vel_in_if  in_ch ();
  vel_out_if out_ch ();
  vel_cfg_if cfg_ch ();

  visible_escape_line_folder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor state: fold width register and the output column.
  logic [7:0] fold_w;
  logic [7:0] line_col;
  vis_word_t  expected_chars[$];

  int in_idle_pct;
  int out_idle_pct;
  int errors;
  int bytes_sent;
  int words_checked;
  int widths_used;
  int stall_cycles;

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Places one visible character and inserts a backslash-newline fold when the
  // column reaches the effective width.
  function automatic void place_char(input logic [7:0] ch);
    logic [7:0] w;
    w = (fold_w < vel_pkg::FOLD_MIN) ? vel_pkg::FOLD_MIN : fold_w;
    expected_chars.push_back('{ch, 1'b0});
    line_col = line_col + 8'd1;
    if (line_col >= w) begin
      expected_chars.push_back('{vel_pkg::CH_BSL, 1'b0});
      expected_chars.push_back('{vel_pkg::CH_NL, 1'b0});
      line_col = 8'd0;
    end
  endfunction

  function automatic logic [7:0] octal_digit(input logic [2:0] d);
    return vel_pkg::CH_ZERO + {5'd0, d};
  endfunction

  // Appends the characters that one accepted line byte produces.
  function automatic void render_byte(input logic [7:0] b);
    vis_word_t tail;
    if (b == 8'd0) begin
      expected_chars.push_back('{vel_pkg::CH_NL, 1'b0});
      line_col = 8'd0;
    end else if (b == vel_pkg::CH_NL) begin
      place_char(vel_pkg::CH_NL);
    end else if (b < 8'd32) begin
      place_char(vel_pkg::CH_BSL);
      place_char(octal_digit(b[5:3]));
      place_char(octal_digit(b[2:0]));
    end else if (b < 8'd127) begin
      place_char(b);
    end else begin
      place_char(vel_pkg::CH_BSL);
      place_char(octal_digit({1'b0, b[7:6]}));
      place_char(octal_digit(b[5:3]));
      place_char(octal_digit(b[2:0]));
    end
    tail = expected_chars.pop_back();
    tail.last = 1'b1;
    expected_chars.push_back(tail);
  endfunction

  // All handshakes are sampled at the falling edge, where every signal has
  // settled and holds the value it will have at the next rising edge.
  always @(negedge clk) begin
    vis_word_t want;
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_checked++;
        if (expected_chars.size() == 0) begin
          $error("unexpected word: out_char=%0h last_of_run=%0b",
                 out_ch.out_char, out_ch.last_of_run);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.out_char !== want.ch) begin
            $error("out_char: expected %0h, actual %0h", want.ch, out_ch.out_char);
            errors++;
          end
          if (out_ch.last_of_run !== want.last) begin
            $error("last_of_run: expected %0b, actual %0b", want.last, out_ch.last_of_run);
            errors++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d words outstanding",
                 stall_cycles, expected_chars.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= out_idle_pct);
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.line_byte <= b;
    @(negedge clk);
    while (!in_ch.ready) @(negedge clk);
    @(posedge clk);
    render_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_fold_width(input logic [7:0] w);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.fold_width <= w;
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    fold_w = w;
    widths_used++;
    cfg_ch.valid <= 1'b0;
  endtask

  // Mixed byte classes; one draw in eight ends the line.
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(7))
      0:       b = 8'd0;
      1:       b = vel_pkg::CH_NL;
      2:       b = 8'($urandom_range(31, 1));
      3:       b = 8'($urandom_range(255, 127));
      default: b = 8'($urandom_range(255, 0));
    endcase
    return b;
  endfunction

  // Every byte class at least once at the reset width of 71.
  task automatic test_byte_classes();
    logic [7:0] picks[11];
    picks = '{8'h41, 8'h20, 8'h7E, 8'h01, 8'h09, 8'h0A, 8'h1F, 8'h7F, 8'h80, 8'hFF, 8'h00};
    foreach (picks[i]) send_byte(picks[i]);
  endtask

  // A width of 2 behaves as 4: plain fold, six-word escape, fold right before
  // the line end, newlines counted as columns, and a fold inside an escape.
  task automatic test_narrow_fold();
    logic [7:0] picks[12];
    picks = '{8'h41, 8'h42, 8'h43, 8'h44, 8'hFF, 8'h00,
              8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'h01, 8'h7F};
    write_fold_width(8'd2);
    foreach (picks[i]) send_byte(picks[i]);
    send_byte(8'h00);
  endtask

  task automatic test_random_short_lines();
    write_fold_width(8'd3);
    for (int i = 0; i < 10; i++) begin
      send_byte(pick_byte());
      // Hold the sender once until the block has emptied completely.
      if (i == 5) wait_drained();
    end
  endtask

  // The widest fold needs one long line: 64 four-character escapes give 256
  // columns, so the fold at 255 always happens before the closing zero.
  task automatic test_random_wide_fold();
    write_fold_width(8'd255);
    for (int i = 0; i < 64; i++) begin
      send_byte(8'($urandom_range(255, 128)));
    end
    send_byte(8'h00);
  endtask

  task automatic test_random_any_width();
    write_fold_width(8'($urandom_range(12, 2)));
    for (int i = 0; i < 5; i++) send_byte(pick_byte());
    write_fold_width(8'($urandom_range(255, 2)));
    for (int i = 0; i < 5; i++) send_byte(pick_byte());
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.line_byte   = 8'd0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.fold_width = 8'd0;
    out_ch.ready      = 1'b0;
    fold_w            = vel_pkg::FOLD_RST;
    line_col          = 8'd0;
    errors            = 0;
    bytes_sent        = 0;
    words_checked     = 0;
    widths_used       = 1;
    stall_cycles      = 0;
    in_idle_pct       = 28;
    out_idle_pct      = 72;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_byte_classes();
    test_narrow_fold();
    test_random_short_lines();

    in_idle_pct  = 72;
    out_idle_pct = 28;
    test_random_wide_fold();

    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_any_width();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_chars.size() != 0) begin
      $error("%0d expected words never arrived", expected_chars.size());
      errors++;
    end

    $display("Sent %0d line bytes under %0d fold widths, from 2 up to 255,", bytes_sent,
             widths_used);
    $display("and checked %0d output words with both sides idling and stalling.",
             words_checked);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### visible_escape_line_folder.f
+incdir+hw/rtl
hw/rtl/vel_pkg.sv
hw/rtl/vel_in_if.sv
hw/rtl/vel_out_if.sv
hw/rtl/vel_cfg_if.sv
hw/rtl/vel_front.sv
hw/rtl/vel_queue.sv
hw/rtl/vel_back.sv
hw/rtl/visible_escape_line_folder.sv
hw/rtl/vel_checker.sv
test/visible_escape_line_folder_test.sv
